FILE: src/mdq_pkg.sv
// ----------------------------------------------------------------------------
// mdq_pkg
// shared types and codes for the multi-discipline queue
// ----------------------------------------------------------------------------
package mdq_pkg;

  // queue disciplines held in the mode register
  localparam logic [1:0] MODE_FIFO   = 2'd0;
  localparam logic [1:0] MODE_LIFO   = 2'd1;
  localparam logic [1:0] MODE_SORTED = 2'd2;
  localparam logic [1:0] MODE_PRIO   = 2'd3;

  // access status codes
  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] data_value;
    logic        [7:0]  priority_req;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic        [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  prio;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic push_step;
    logic pop_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_op;
    logic full;
    logic empty;
    logic done;
  } dp_status_t;

endpackage

FILE: src/mdq_ctrl.sv
// ----------------------------------------------------------------------------
// mdq_ctrl
// sequencer for accept, memory sweep and result hand-off
// ----------------------------------------------------------------------------
module mdq_ctrl import mdq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  output logic       result_valid,
  input  logic       result_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PUSH   = 4'b0010,
    S_POP    = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   item_take;
  logic   out_free;

  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_take) begin
          cmd.load = 1'b1;
          if (status.in_op == OP_PUSH) begin
            state_next = status.full ? S_FINISH : S_PUSH;
          end else begin
            state_next = status.empty ? S_FINISH : S_POP;
          end
        end
      end
      S_PUSH: begin
        cmd.push_step = 1'b1;
        if (status.done) state_next = S_FINISH;
      end
      S_POP: begin
        cmd.pop_step = 1'b1;
        if (status.done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && result_valid && result_stall) |=> state == S_FINISH)
    else $error("result overwritten while stalled");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE && item_valid))
    else $error("item loaded outside idle");
  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_FINISH)
    else $error("result raised without finish");
`endif

endmodule

FILE: src/mdq_datapath.sv
// ----------------------------------------------------------------------------
// mdq_datapath
// entry memory, sweep counters, insert carry and result registers
// ----------------------------------------------------------------------------
module mdq_datapath import mdq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_data,
  input  in_word_t   item,
  output out_word_t  result,
  input  dp_cmd_t    cmd,
  output dp_status_t status
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_data;
  entry_t        carry;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic          issue;

  logic [1:0]    mode;
  in_word_t      held;
  out_word_t     res;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] d_idx;
  logic [CW-1:0] d_prev;
  logic [CW-1:0] pos;
  logic [CW-1:0] start;
  logic          pend;
  logic          found;
  logic          hit;
  logic          take_slot;

  assign status.in_op = item.operation;
  assign status.full  = (count == DEPTH_C);
  assign status.empty = (count == '0);
  assign status.done  = !pend && (rd_idx == count);

  assign issue   = (cmd.push_step || cmd.pop_step) && (rd_idx < count);
  assign rd_addr = rd_idx[AW-1:0];
  assign d_prev  = d_idx - 1'b1;

  // does the new entry go in front of the entry just read
  always_comb begin
    case (mode)
      MODE_FIFO:   hit = 1'b1;
      MODE_LIFO:   hit = 1'b0;
      MODE_SORTED: hit = (held.data_value >= $signed(rd_data.value));
      MODE_PRIO:   hit = (held.priority_req >= rd_data.prio);
      default:     hit = 1'b0;
    endcase
  end

  assign take_slot = cmd.push_step && pend && (found || hit);

  // first address of the sweep
  always_comb begin
    if (item.operation == OP_PUSH) begin
      start = (mode == MODE_LIFO) ? count : '0;
    end else begin
      start = (mode == MODE_SORTED) ? '0 : count - 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = d_idx[AW-1:0];
    wr_data = carry;
    if (cmd.push_step) begin
      if (take_slot) begin
        wr_en = 1'b1;
      end else if (status.done) begin
        wr_en   = 1'b1;
        wr_addr = count[AW-1:0];
      end
    end else if (cmd.pop_step && pend && (d_idx != pos)) begin
      wr_en   = 1'b1;
      wr_addr = d_prev[AW-1:0];
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mode  <= MODE_FIFO;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cfg_valid) mode <= cfg_data;
      pend <= issue;
      if (cmd.load) begin
        found <= 1'b0;
      end else if (take_slot) begin
        found <= 1'b1;
      end
      if (cmd.push_step && status.done) begin
        count <= count + 1'b1;
      end else if (cmd.pop_step && status.done) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held         <= item;
      carry.value  <= item.data_value;
      carry.prio   <= item.priority_req;
      rd_idx       <= start;
      pos          <= start;
      res.popped_value <= '0;
      if (item.operation == OP_PUSH) begin
        res.status <= status.full ? ST_FULL : ST_PUSHED;
      end else begin
        res.status <= status.empty ? ST_EMPTY : ST_POPPED;
      end
    end else if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (issue) d_idx <= rd_idx;
    if (take_slot) carry <= rd_data;
    if (cmd.pop_step && pend && (d_idx == pos)) begin
      res.popped_value <= $signed(rd_data.value);
    end
    if (cmd.out_load) result <= res;
  end

`ifndef SYNTHESIS
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_step && status.done) |=> count == $past(count) + 1'b1)
    else $error("push did not grow the queue");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_step && status.done) |=> count == $past(count) - 1'b1)
    else $error("pop did not shrink the queue");
  a_read_live: assert property (@(posedge clk) disable iff (rst)
    pend |-> d_idx < count)
    else $error("read beyond live entries");
`endif

endmodule

FILE: src/multi_discipline_queue_top.sv
// ----------------------------------------------------------------------------
// multi_discipline_queue_top
// bounded queue of value and priority entries with selectable discipline
// ----------------------------------------------------------------------------
// A bounded queue of up to QUEUE_DEPTH entries kept as one ordered list in a
// single-port-read, single-port-write memory. The mode register selects fifo,
// lifo, sorted by signed value (largest popped first) or priority (smallest
// priority popped first, oldest of its level). Each input word is a push or a
// pop and produces exactly one result word with a status; a pop on an empty
// queue and a push on a full one leave the queue untouched. One word is worked
// on at a time. Insertion in every mode but lifo and removal in sorted mode
// sweep the live entries once through the memory read port; lifo pushes and
// the other pops read at most one entry, and rejected accesses read none.
// Entries are not cleared at reset and need no clearing pass. Mode is to be
// written only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module multi_discipline_queue_top import mdq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       item_valid,
  output logic       item_stall,
  input  in_word_t   item,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output out_word_t  result,
  // mode register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // mode writes are always taken; they are to be made only while the queue is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  // sequencer: accept, sweep and result hand-off
  mdq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  // entry memory and the insert or remove sweep
  mdq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: sim/multi_discipline_queue_top_tb.sv
// ----------------------------------------------------------------------------
// multi_discipline_queue_top_tb
// self-checking bench for the multi-discipline queue
// ----------------------------------------------------------------------------
// A queue of pending jobs drives the item port and the mode register. Each job
// is either a push or pop word or a mode write. Every accepted word runs
// through a local queue model, and the model's answer joins a store of awaited
// answers. The monitor checks each result word against the oldest awaited one.
// A short directed run covers the extreme values, every mode and the special
// accesses. Random phases follow, and each one fills, drains or churns the
// queue. Both sides pause at random.
// ----------------------------------------------------------------------------
module multi_discipline_queue_top_tb;
  import mdq_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int RANDOM_WORDS  = 1950;
  localparam int WATCHDOG_MAX  = 3000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 4;     // idle cycles before a mode write
  localparam int TAIL_CYCLES   = 40;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  // one pending job: a word for the item port or a mode write
  typedef struct {
    bit         is_mode;
    logic [1:0] mode;
    in_word_t   word;
  } job_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  in_word_t   item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  out_word_t  result;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data     = '0;

  job_t      pending_jobs[$];
  out_word_t awaited_results[$];

  // queue model state: head at position 0, tail at model_count-1
  logic signed [31:0] model_val [QUEUE_DEPTH];
  logic        [7:0]  model_prio[QUEUE_DEPTH];
  int                 model_count = 0;
  logic        [1:0]  model_mode  = MODE_FIFO;

  int error_count   = 0;
  int quiet_cycles  = 0;
  int random_words  = 0;

  always #4 clk = ~clk;

  multi_discipline_queue_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // queue model: applies one word and returns the answer it gives
  // --------------------------------------------------------------------------
  function automatic out_word_t queue_access(in_word_t w);
    out_word_t ans;
    int        pos;
    int        i;
    ans.popped_value = '0;
    pos = 0;
    if (w.operation == OP_PUSH) begin
      if (model_count >= QUEUE_DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        case (model_mode)
          MODE_FIFO: begin
            pos = 0;
          end
          MODE_LIFO: begin
            pos = model_count;
          end
          MODE_SORTED: begin
            // new value goes ahead of the first entry it is >= to
            while (pos < model_count && !(w.data_value >= model_val[pos])) pos++;
          end
          default: begin
            // new entry goes ahead of the first of lower or equal priority
            while (pos < model_count && w.priority_req < model_prio[pos]) pos++;
          end
        endcase
        for (i = model_count; i > pos; i--) begin
          model_val[i]  = model_val[i-1];
          model_prio[i] = model_prio[i-1];
        end
        model_val[pos]  = w.data_value;
        model_prio[pos] = w.priority_req;
        model_count++;
        ans.status = ST_PUSHED;
      end
    end else begin
      if (model_count == 0) begin
        ans.status = ST_EMPTY;
      end else begin
        // sorted pops the head, every other mode pops the tail
        pos = (model_mode == MODE_SORTED) ? 0 : model_count - 1;
        ans.popped_value = model_val[pos];
        for (i = pos; i + 1 < model_count; i++) begin
          model_val[i]  = model_val[i+1];
          model_prio[i] = model_prio[i+1];
        end
        model_count--;
        ans.status = ST_POPPED;
      end
    end
    return ans;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_word(logic op, logic signed [31:0] v, logic [7:0] p);
    job_t j;
    j.is_mode           = 1'b0;
    j.mode              = '0;
    j.word.operation    = op;
    j.word.data_value   = v;
    j.word.priority_req = p;
    pending_jobs.push_back(j);
  endfunction

  function automatic void add_mode(logic [1:0] m);
    job_t j;
    j.is_mode = 1'b1;
    j.mode    = m;
    j.word    = '0;
    pending_jobs.push_back(j);
  endfunction

  // extremes and a narrow band around zero so that ties are common
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:          return 8'd0;
      1:          return 8'd255;
      2, 3, 4:    return 8'($urandom_range(0, 7));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // driver: one nonblocking write per signal per edge
  // --------------------------------------------------------------------------
  int   item_gap     = 0;
  int   item_calm    = 0;
  int   settle_count = 0;

  always @(posedge clk) begin
    logic     nxt_valid;
    in_word_t nxt_item;
    logic     nxt_cfg_valid;
    logic [1:0] nxt_cfg_data;
    bit       word_taken;
    bit       mode_taken;
    nxt_valid     = item_valid;
    nxt_item      = item;
    nxt_cfg_valid = cfg_valid;
    nxt_cfg_data  = cfg_data;
    word_taken    = item_valid && !item_stall;
    mode_taken    = cfg_valid && cfg_ready;
    if (!rst) begin
      // accepted word: run it through the model straight away
      if (word_taken) begin
        awaited_results.push_back(queue_access(item));
        nxt_valid = 1'b0;
        item_gap  = (item_calm > 0) ? 0 : pick_gap();
      end
      if (mode_taken) begin
        model_mode    = cfg_data;
        nxt_cfg_valid = 1'b0;
      end
      // block counts as settled once all answers are in and the port is quiet
      if (awaited_results.size() == 0 && !item_valid && !cfg_valid)
        settle_count++;
      else
        settle_count = 0;
      if (item_calm > 0)
        item_calm--;
      else if ($urandom_range(0, 299) == 0)
        item_calm = $urandom_range(100, 300);
      if (!nxt_valid && !nxt_cfg_valid && !word_taken && !mode_taken) begin
        if (item_gap > 0) begin
          item_gap--;
        end else if (pending_jobs.size() > 0) begin
          if (pending_jobs[0].is_mode) begin
            // mode writes only go out to an idle block
            if (settle_count >= SETTLE_CYCLES) begin
              nxt_cfg_valid = 1'b1;
              nxt_cfg_data  = pending_jobs[0].mode;
              void'(pending_jobs.pop_front());
            end
          end else begin
            nxt_valid = 1'b1;
            nxt_item  = pending_jobs[0].word;
            void'(pending_jobs.pop_front());
          end
        end
      end else if (!nxt_valid && !nxt_cfg_valid && item_gap == 0 &&
                   pending_jobs.size() > 0 && !pending_jobs[0].is_mode) begin
        // back-to-back word straight after an accept
        nxt_valid = 1'b1;
        nxt_item  = pending_jobs[0].word;
        void'(pending_jobs.pop_front());
      end
    end
    item_valid <= nxt_valid;
    item       <= nxt_item;
    cfg_valid  <= nxt_cfg_valid;
    cfg_data   <= nxt_cfg_data;
  end

  // --------------------------------------------------------------------------
  // monitor: checks result words and drives the stall
  // --------------------------------------------------------------------------
  int stall_left  = 0;
  int result_calm = 0;

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word, popped_value %0d status %0d",
                 $time, result.popped_value, result.status);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (result.popped_value !== want.popped_value) begin
          $display("%0t: popped_value mismatch, expected %0d actual %0d",
                   $time, want.popped_value, result.popped_value);
          error_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, result.status);
          error_count++;
        end
      end
    end
    if (result_calm > 0)
      result_calm--;
    else if ($urandom_range(0, 299) == 0)
      result_calm = $urandom_range(100, 300);
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (result_calm == 0 && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
    end
  end

  // watchdog: cycles in which no handshake of any kind took place
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // stimulus build, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    int len;
    int push_pct;
    int n;
    logic [1:0] m;

    // fifo: pop on empty, extreme values, oldest pops first
    add_mode(MODE_FIFO);
    add_word(OP_POP,  pick_value(), pick_prio());
    add_word(OP_PUSH, VAL_MAX, 8'd255);
    add_word(OP_PUSH, VAL_MIN, 8'd0);
    add_word(OP_PUSH, 32'sd0,  8'd128);
    add_word(OP_POP,  32'sd0,  8'd0);
    add_word(OP_POP,  -32'sd1, 8'd255);
    // lifo on the entry left over, then drain past empty
    add_mode(MODE_LIFO);
    add_word(OP_PUSH, -32'sd1, 8'd1);
    add_word(OP_PUSH, 32'sd1,  8'd2);
    add_word(OP_POP,  32'sd0,  8'd0);
    add_word(OP_POP,  32'sd0,  8'd0);
    add_word(OP_POP,  32'sd0,  8'd0);
    add_word(OP_POP,  32'sd0,  8'd0);
    // sorted: equal values, both extremes, largest pops first
    add_mode(MODE_SORTED);
    add_word(OP_PUSH, 32'sd5,  8'd3);
    add_word(OP_PUSH, 32'sd5,  8'd4);
    add_word(OP_PUSH, -32'sd7, 8'd0);
    add_word(OP_PUSH, VAL_MAX, 8'd9);
    add_word(OP_PUSH, VAL_MIN, 8'd9);
    add_word(OP_POP,  32'sd0,  8'd0);
    // priority on a list that was ordered by value, no reordering expected
    add_mode(MODE_PRIO);
    add_word(OP_PUSH, 32'sd100, 8'd6);
    add_word(OP_PUSH, 32'sd200, 8'd255);
    add_word(OP_PUSH, 32'sd300, 8'd0);
    add_word(OP_POP,  32'sd0,   8'd0);
    add_word(OP_POP,  32'sd0,   8'd0);

    // random phases: fill, drain or churn under a chosen mode
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      m = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
      add_mode(m);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      len = $urandom_range(40, 120);
      for (n = 0; n < len; n++) begin
        if ($urandom_range(0, 99) < push_pct)
          add_word(OP_PUSH, pick_value(), pick_prio());
        else
          add_word(OP_POP, $urandom, 8'($urandom));
      end
      random_words += len;
      phase++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wait until every job has gone out and every answer has come back
    @(negedge clk);
    while (!(pending_jobs.size() == 0 && !item_valid && !cfg_valid &&
             awaited_results.size() == 0) && quiet_cycles < WATCHDOG_MAX)
      @(negedge clk);

    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("Some tests failed");
    end else begin
      // let any stray word show itself
      repeat (TAIL_CYCLES) @(negedge clk);
      if (error_count == 0 && awaited_results.size() == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
    end
    $finish;
  end

endmodule
